// File: design/stereo_peak_normalizer_unit_macros.svh
// Assertion macros shared by the stereo peak normalizer RTL.
`ifndef STEREO_PEAK_NORMALIZER_UNIT_MACROS_SVH
`define STEREO_PEAK_NORMALIZER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SNORM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SNORM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/snorm_pkg.sv
// Shared types and constants of the stereo peak normalizer.
package snorm_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int GAIN_W    = 15;
	localparam int DIVISOR_W = GAIN_W + 1;

	// Numerator of the gain division.
	localparam logic [GAIN_W-1:0] FULL_SCALE = 15'h7FFF;

	// Status of the serial divider.
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PEAK,
		ST_DIV,
		ST_MUL_L,
		ST_MUL_R,
		ST_OUT
	} snorm_state_t;

endpackage

// File: design/snorm_div.sv
// Restoring serial divider that forms FULL_SCALE / divisor, one quotient bit per cycle.
module snorm_div import snorm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DIVISOR_W-1:0] divisor,
	output div_stat_t            stat,
	output logic [GAIN_W-1:0]    quotient
);

	localparam logic [3:0] LAST_STEP = 4'(GAIN_W - 1);

	logic                 busy_q;
	logic                 done_q;
	logic [3:0]           cnt_q;
	logic [DIVISOR_W-1:0] rem_q;
	logic [DIVISOR_W-1:0] div_q;
	logic [GAIN_W-1:0]    quo_q;

	logic [3:0]           bit_idx;
	logic [DIVISOR_W:0]   trial;
	logic [DIVISOR_W:0]   diff;
	logic                 fits;

	// Bring down the next numerator bit, most significant first.
	always_comb begin
		bit_idx = LAST_STEP - cnt_q;
		trial   = {rem_q, FULL_SCALE[bit_idx]};
		diff    = trial - {1'b0, div_q};
		fits    = trial >= {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The remainder stays below the divisor, so it always fits DIVISOR_W bits.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			div_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
			quo_q <= {quo_q[GAIN_W-2:0], fits};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule

// File: design/stereo_peak_normalizer_unit.sv
// Top level of the stereo peak normalizer: sequencer, peak register and shared multiplier.
//
// Each word on the input channel is one stereo pair of signed 16-bit samples. The block
// holds a peak magnitude that only rises (reset clears it to zero); the pair first raises
// it with the left magnitude, then with the right, where the magnitude of -32768 is taken
// as 32767. The gain floor(32767 / (peak + 1)) is then formed by a serial restoring
// divider that yields one quotient bit per clock, and both samples are multiplied by it on
// one shared 16 x 16 multiplier, left first, then right. The output word carries both
// products and the gain that was used; the products always fit 16 bits. The block works
// on one pair at a time and drops in_ready from acceptance until its result word is taken.
// With out_ready held high a pair goes from one acceptance to the next through these steps:
// update the peak and start the divider, the divider steps, take the quotient, the left
// and right multiplier steps, the output word, and acceptance of the next pair. The
// divider loop is the longest of these steps.
`include "stereo_peak_normalizer_unit_macros.svh"

module stereo_peak_normalizer_unit import snorm_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [SAMPLE_W-1:0] left_sample,
	input  logic signed [SAMPLE_W-1:0] right_sample,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [SAMPLE_W-1:0] left_scaled,
	output logic signed [SAMPLE_W-1:0] right_scaled,
	output logic [GAIN_W-1:0]          gain_used
);

	// Magnitude of a sample; the most negative code saturates to full scale.
	function automatic logic [GAIN_W-1:0] mag_sat(input logic signed [SAMPLE_W-1:0] s);
		logic [SAMPLE_W-1:0] neg;
		neg = SAMPLE_W'(-s);
		if (s == {1'b1, {(SAMPLE_W-1){1'b0}}}) begin
			return FULL_SCALE;
		end else if (s[SAMPLE_W-1]) begin
			return neg[GAIN_W-1:0];
		end else begin
			return s[GAIN_W-1:0];
		end
	endfunction

	snorm_state_t state_q;
	snorm_state_t state_d;

	logic [GAIN_W-1:0]          peak_q;
	logic [GAIN_W-1:0]          gain_q;
	logic signed [SAMPLE_W-1:0] left_q;
	logic signed [SAMPLE_W-1:0] right_q;
	logic signed [SAMPLE_W-1:0] left_scaled_q;
	logic signed [SAMPLE_W-1:0] right_scaled_q;

	logic [GAIN_W-1:0]          mag_l;
	logic [GAIN_W-1:0]          mag_r;
	logic [GAIN_W-1:0]          peak_after_l;
	logic [GAIN_W-1:0]          peak_new;
	logic [DIVISOR_W-1:0]       divisor;
	logic                       div_start;
	div_stat_t                  div_stat;
	logic [GAIN_W-1:0]          quotient;

	logic signed [SAMPLE_W-1:0] mul_a;
	logic signed [31:0]         product;

	// The peak is raised by the left magnitude first, then by the right one.
	always_comb begin
		mag_l        = mag_sat(left_q);
		mag_r        = mag_sat(right_q);
		peak_after_l = (mag_l > peak_q) ? mag_l : peak_q;
		peak_new     = (mag_r > peak_after_l) ? mag_r : peak_after_l;
		divisor      = {1'b0, peak_new} + DIVISOR_W'(1);
	end

	snorm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.divisor  (divisor),
		.stat     (div_stat),
		.quotient (quotient)
	);

	// One multiplier serves both channels; the gain is zero-extended to a signed operand.
	assign mul_a   = (state_q == ST_MUL_R) ? right_q : left_q;
	assign product = 32'(mul_a) * 32'($signed({1'b0, gain_q}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			peak_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_PEAK) begin
				peak_q <= peak_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			left_q  <= left_sample;
			right_q <= right_sample;
		end
		if (div_stat.done) begin
			gain_q <= quotient;
		end
		if (state_q == ST_MUL_L) begin
			left_scaled_q <= product[SAMPLE_W-1:0];
		end
		if (state_q == ST_MUL_R) begin
			right_scaled_q <= product[SAMPLE_W-1:0];
		end
	end

	// Sequencer: next state and handshake outputs.
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		div_start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_PEAK;
				end
			end
			ST_PEAK: begin
				div_start = 1'b1;
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				if (div_stat.done) begin
					state_d = ST_MUL_L;
				end
			end
			ST_MUL_L: begin
				state_d = ST_MUL_R;
			end
			ST_MUL_R: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign left_scaled  = left_scaled_q;
	assign right_scaled = right_scaled_q;
	assign gain_used    = gain_q;

	`SNORM_ASSERT_NEXT(a_peak_monotonic, clk, arst_n, 1'b1, peak_q >= $past(peak_q), "peak level decreased")
	`SNORM_ASSERT_IMPL(a_start_idle_div, clk, arst_n, div_start, !div_stat.busy, "divider restarted while busy")
	`SNORM_ASSERT_IMPL(a_gain_floor, clk, arst_n, out_valid, ((32'(gain_q) * (32'(peak_q) + 32'd1)) <= 32'(FULL_SCALE)) && ((32'(gain_q) * (32'(peak_q) + 32'd1)) + 32'(peak_q) + 32'd1 > 32'(FULL_SCALE)), "gain is not the floor quotient of the peak")

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the stereo peak normalizer unit.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import snorm_pkg::*;

	localparam int RANDOM_PAIRS    = 950;
	localparam int CYCLE_LIMIT     = 400_000;
	// Time to watch for stray output words once every expected word has arrived.
	localparam int DRAIN_CYCLES    = 42;
	localparam int HOLD_OFF_CYCLES = 250;
	localparam int REPORT_LINES    = 100;
	// Random samples stay one step short of full scale so that the peak cannot saturate
	// before the full-scale test runs at the very end.
	localparam int RANDOM_LIMIT    = int'(FULL_SCALE) - 1;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	// One output word as the block should present it.
	typedef struct {
		sample_t           left;
		sample_t           right;
		logic [GAIN_W-1:0] gain;
	} scaled_pair_t;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    in_valid     = 1'b0;
	logic    in_ready;
	sample_t left_sample  = '0;
	sample_t right_sample = '0;
	logic    out_valid;
	logic    out_ready    = 1'b0;
	sample_t left_scaled;
	sample_t right_scaled;
	logic [GAIN_W-1:0] gain_used;

	// Predicted peak magnitude; like the block's own register it only ever rises.
	logic [GAIN_W-1:0] peak_hold = '0;
	// Output words still owed by the block, oldest first.
	scaled_pair_t expected_scaled[$];

	int mismatch_count = 0;
	int cycle_count    = 0;
	int send_idle_pct  = 0;
	int recv_idle_pct  = 0;
	int hold_request   = 0;
	int hold_left      = 0;
	int random_index   = 0;

	stereo_peak_normalizer_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.left_sample  (left_sample),
		.right_sample (right_sample),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.left_scaled  (left_scaled),
		.right_scaled (right_scaled),
		.gain_used    (gain_used)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The magnitude of a sample; -32768 has no positive twin and is clipped to full scale.
	function automatic logic [GAIN_W-1:0] clipped_magnitude(sample_t s);
		int m;
		m = (s < 0) ? -int'(s) : int'(s);
		return (m > int'(FULL_SCALE)) ? FULL_SCALE : GAIN_W'(m);
	endfunction

	// Raises the peak with the left magnitude, then the right, and scales both samples by
	// the integer gain floor(32767 / (peak + 1)). The products always fit 16 bits.
	function automatic scaled_pair_t normalize_pair(sample_t l, sample_t r);
		scaled_pair_t      res;
		logic [GAIN_W-1:0] mag_l;
		logic [GAIN_W-1:0] mag_r;
		int                gain;
		mag_l = clipped_magnitude(l);
		mag_r = clipped_magnitude(r);
		if (mag_l > peak_hold) begin
			peak_hold = mag_l;
		end
		if (mag_r > peak_hold) begin
			peak_hold = mag_r;
		end
		gain = int'(FULL_SCALE) / (int'(peak_hold) + 1);
		res.left  = SAMPLE_W'(int'(l) * gain);
		res.right = SAMPLE_W'(int'(r) * gain);
		res.gain  = GAIN_W'(gain);
		return res;
	endfunction

	// Mostly a uniform sample within +-cap. Now and then the sample lands exactly on the
	// current peak or one above it, so that ties and single-step rises of the peak occur.
	function automatic sample_t random_sample(int cap);
		int v;
		case ($urandom_range(9))
			0: begin
				v = int'(peak_hold);
				v = $urandom_range(1) ? -v : v;
			end
			1: begin
				v = (int'(peak_hold) + 1 > cap) ? cap : int'(peak_hold) + 1;
				v = $urandom_range(1) ? -v : v;
			end
			default: begin
				v = int'($urandom_range(2 * cap)) - cap;
			end
		endcase
		return SAMPLE_W'(v);
	endfunction

	task automatic flag_mismatch(string what);
		if (mismatch_count < REPORT_LINES) begin
			$display("MISMATCH at cycle %0d: %s", cycle_count, what);
		end
		mismatch_count++;
	endtask

	// Offers one stereo pair and waits for it to be taken. It is entered at a falling edge
	// and returns at one. Valid is left high on return, so back-to-back words need no gap;
	// the next call lowers it only when it decides to idle.
	task automatic send_pair(sample_t l, sample_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		left_sample  <= l;
		right_sample <= r;
		do @(posedge clk); while (!in_ready);
		expected_scaled.push_back(normalize_pair(l, r));
		@(negedge clk);
	endtask

	// The receiver. A hold-off request is copied into its own counter and holds ready low
	// until that counter has run down; otherwise ready drops at random with the current idle rate.
	always @(negedge clk) begin
		if (hold_request != 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Each word taken from the output is matched against the oldest prediction.
	always @(posedge clk) begin : result_check
		scaled_pair_t due;
		if (arst_n && out_valid && out_ready) begin
			if (expected_scaled.size() == 0) begin
				flag_mismatch($sformatf("output word %0d/%0d/%0d with none expected",
					left_scaled, right_scaled, gain_used));
			end else begin
				due = expected_scaled.pop_front();
				if (left_scaled !== due.left) begin
					flag_mismatch($sformatf("left_scaled %0d, expected %0d",
						left_scaled, due.left));
				end
				if (right_scaled !== due.right) begin
					flag_mismatch($sformatf("right_scaled %0d, expected %0d",
						right_scaled, due.right));
				end
				if (gain_used !== due.gain) begin
					flag_mismatch($sformatf("gain_used %0d, expected %0d",
						gain_used, due.gain));
				end
			end
		end
	end

	// Watchdog: a hung handshake or a lost output word ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d words outstanding", cycle_count,
				expected_scaled.size());
			$display("testbench NOT OK");
			$finish;
		end
	end

	// Silence right after reset: the peak is zero, so the gain is at its largest.
	task automatic test_silence();
		send_idle_pct = 34;
		recv_idle_pct = 73;
		send_pair(16'sd0, 16'sd0);
		send_pair(16'sd0, 16'sd0);
	endtask

	// Low levels where each step of the peak changes the gain a lot. The order covers a
	// peak raised by the left sample, by the right, by both, and by neither.
	task automatic test_small_levels();
		send_pair(16'sd1, 16'sd0);
		send_pair(-16'sd1, 16'sd1);
		send_pair(16'sd0, -16'sd2);
		send_pair(16'sd2, -16'sd5);
		send_pair(16'sd7, -16'sd9);
		send_pair(16'sd12, 16'sd4);
		send_pair(-16'sd6, 16'sd3);
		send_pair(-16'sd12, 16'sd12);
	endtask

	// Random pairs whose range widens with the global word count, from one bit up to
	// nearly full scale, so the held peak climbs through every gain region once.
	task automatic run_random_pairs(int count);
		int bits;
		int cap;
		repeat (count) begin
			bits = 1 + (random_index * 15) / RANDOM_PAIRS;
			cap  = (1 << bits) - 1;
			if (cap > RANDOM_LIMIT) begin
				cap = RANDOM_LIMIT;
			end
			send_pair(random_sample(cap), random_sample(cap));
			random_index++;
		end
	endtask

	task automatic test_random_slow_receiver();
		send_idle_pct = 34;
		recv_idle_pct = 73;
		run_random_pairs(317);
	endtask

	task automatic test_random_slow_sender();
		send_idle_pct = 73;
		recv_idle_pct = 34;
		run_random_pairs(317);
	endtask

	task automatic test_random_streaming();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random_pairs(RANDOM_PAIRS - 634);
	endtask

	// The receiver stops for a long stretch while words keep coming, so the block holds
	// its finished word and must keep in_ready low until the receiver returns.
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_request  = HOLD_OFF_CYCLES;
		repeat (6) begin
			send_pair(random_sample(RANDOM_LIMIT), random_sample(RANDOM_LIMIT));
		end
	endtask

	// Full-scale pairs come last because the peak never falls. A peak of 32766 gives a
	// gain of one; -32768 must then clip to 32767 and drive the gain to zero, and it
	// stays zero for every later word.
	task automatic test_full_scale();
		send_idle_pct = 34;
		recv_idle_pct = 34;
		send_pair(16'sd32766, -16'sd32766);
		send_pair(-16'sd32766, 16'sd32765);
		send_pair(-16'sd32768, 16'sd0);
		send_pair(16'sd32767, -16'sd32767);
		send_pair(-16'sd32768, -16'sd32768);
		send_pair(16'sd0, 16'sd32767);
	endtask

	initial begin
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_silence();
		test_small_levels();
		test_random_slow_receiver();
		test_random_slow_sender();
		test_random_streaming();
		test_backpressure();
		test_full_scale();
		in_valid <= 1'b0;

		// Let every owed word arrive, then watch a little longer for stray ones.
		while (expected_scaled.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule
